FILE: src/mie_pkg.sv
// types and constants for the mips64 integer execute block
// no dependencies
package mie_pkg;

  localparam logic [31:0] MASK32 = 32'hffff_ffff;
  localparam logic [4:0]  MASK5  = 5'h1f;
  localparam logic [5:0]  MASK6  = 6'h3f;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;
  localparam logic [5:0] OP_DADDI   = 6'd24;
  localparam logic [5:0] OP_DADDIU  = 6'd25;

  localparam logic [5:0] FN_SLL    = 6'd0;
  localparam logic [5:0] FN_SRL    = 6'd2;
  localparam logic [5:0] FN_SRA    = 6'd3;
  localparam logic [5:0] FN_SLLV   = 6'd4;
  localparam logic [5:0] FN_SRLV   = 6'd6;
  localparam logic [5:0] FN_SRAV   = 6'd7;
  localparam logic [5:0] FN_JR     = 6'd8;
  localparam logic [5:0] FN_JALR   = 6'd9;
  localparam logic [5:0] FN_MOVZ   = 6'd10;
  localparam logic [5:0] FN_MOVN   = 6'd11;
  localparam logic [5:0] FN_MFHI   = 6'd16;
  localparam logic [5:0] FN_MTHI   = 6'd17;
  localparam logic [5:0] FN_MFLO   = 6'd18;
  localparam logic [5:0] FN_MTLO   = 6'd19;
  localparam logic [5:0] FN_DSLLV  = 6'd20;
  localparam logic [5:0] FN_DSRLV  = 6'd22;
  localparam logic [5:0] FN_DSRAV  = 6'd23;
  localparam logic [5:0] FN_MULT   = 6'd24;
  localparam logic [5:0] FN_MULTU  = 6'd25;
  localparam logic [5:0] FN_DIV    = 6'd26;
  localparam logic [5:0] FN_DIVU   = 6'd27;
  localparam logic [5:0] FN_ADD    = 6'd32;
  localparam logic [5:0] FN_ADDU   = 6'd33;
  localparam logic [5:0] FN_SUB    = 6'd34;
  localparam logic [5:0] FN_SUBU   = 6'd35;
  localparam logic [5:0] FN_AND    = 6'd36;
  localparam logic [5:0] FN_OR     = 6'd37;
  localparam logic [5:0] FN_XOR    = 6'd38;
  localparam logic [5:0] FN_NOR    = 6'd39;
  localparam logic [5:0] FN_SLT    = 6'd42;
  localparam logic [5:0] FN_SLTU   = 6'd43;
  localparam logic [5:0] FN_DADD   = 6'd44;
  localparam logic [5:0] FN_DADDU  = 6'd45;
  localparam logic [5:0] FN_DSUB   = 6'd46;
  localparam logic [5:0] FN_DSUBU  = 6'd47;
  localparam logic [5:0] FN_DSLL   = 6'd56;
  localparam logic [5:0] FN_DSRL   = 6'd58;
  localparam logic [5:0] FN_DSRA   = 6'd59;
  localparam logic [5:0] FN_DSLL32 = 6'd60;
  localparam logic [5:0] FN_DSRL32 = 6'd62;
  localparam logic [5:0] FN_DSRA32 = 6'd63;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] inst_address;
  } mie_in_t;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        nullify_next;
    logic        unsupported;
  } mie_out_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

endpackage

FILE: src/mips64_integer_execute.sv
// mips64 integer execute: top level with register file, hi/lo and divider
// depends on mie_pkg
// One instruction word is taken at a time. Register operands are read from a
// synchronous 32x64 memory (two read ports, one write port) at the accepting
// edge; the word then passes through the states S_READ and S_EXEC, where the
// result is computed and the write-back happens as the result is registered.
// The result is valid in S_OUT, and a new word can be accepted in the cycle
// after the result leaves the output register. MULT/MULTU pass through S_MUL
// for the registered product. DIV and DIVU with a nonzero divisor run a
// radix-2 restoring divider in S_DIV. Register zero is not
// stored; the memory contents are kept valid per entry by a 32-bit valid
// vector cleared at reset, so no clearing pass is needed.
module mips64_integer_execute (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mie_pkg::mie_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mie_pkg::mie_out_t out_data
);
  import mie_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_EXEC = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] gpr_mem [32];
  logic [31:0] gpr_vld_r;
  logic [63:0] rd_s_r, rd_t_r;
  logic [63:0] hi_r, lo_r;
  logic [31:0] ins_r, pc_r;
  mie_out_t    res_r;

  logic [4:0] rs, rt, rd, sa;
  logic [5:0] op, fn;
  assign op = ins_r[31:26];
  assign rs = ins_r[25:21];
  assign rt = ins_r[20:16];
  assign rd = ins_r[15:11];
  assign sa = ins_r[10:6];
  assign fn = ins_r[5:0];

  logic [63:0] vs, vt;
  assign vs = (rs == 5'd0 || !gpr_vld_r[rs]) ? 64'd0 : rd_s_r;
  assign vt = (rt == 5'd0 || !gpr_vld_r[rt]) ? 64'd0 : rd_t_r;

  // exec decode
  logic        wr, tk, nul, uns, cond, likely, isbr, hi_we, lo_we, is_mul, is_div;
  logic [4:0]  dst;
  logic [63:0] val, hi_v, lo_v, imm_s, imm_u, link;
  logic [31:0] tgt, btgt;
  logic [5:0]  sh6;

  assign imm_s = {{48{ins_r[15]}}, ins_r[15:0]};
  assign imm_u = {48'd0, ins_r[15:0]};
  assign btgt  = pc_r + 32'd4 + {imm_s[29:0], 2'b00};
  assign link  = {32'd0, pc_r + 32'd8};

  always_comb begin
    wr = 1'b0; tk = 1'b0; nul = 1'b0; uns = 1'b0; cond = 1'b0; likely = 1'b0;
    isbr = 1'b0; hi_we = 1'b0; lo_we = 1'b0; is_mul = 1'b0; is_div = 1'b0;
    dst = 5'd0; val = 64'd0; hi_v = vs; lo_v = vs; tgt = 32'd0; sh6 = 6'd0;
    case (op)
      OP_SPECIAL: begin
        wr = 1'b1; dst = rd;
        case (fn)
          FN_SLL:  val = sx32(vt[31:0] << sa);
          FN_SRL:  val = sx32(vt[31:0] >> sa);
          FN_SRA:  val = sx32($signed(vt[31:0]) >>> sa);
          FN_SLLV: val = sx32(vt[31:0] << vs[4:0]);
          FN_SRLV: val = sx32(vt[31:0] >> vs[4:0]);
          FN_SRAV: val = sx32($signed(vt[31:0]) >>> vs[4:0]);
          FN_JR: begin
            wr = 1'b0; tk = 1'b1; tgt = vs[31:0];
          end
          FN_JALR: begin
            val = link; tk = 1'b1; tgt = vs[31:0];
          end
          FN_MOVZ: begin
            wr = (vt == 64'd0); val = vs;
          end
          FN_MOVN: begin
            wr = (vt != 64'd0); val = vs;
          end
          FN_MFHI: val = hi_r;
          FN_MTHI: begin
            wr = 1'b0; hi_we = 1'b1;
          end
          FN_MFLO: val = lo_r;
          FN_MTLO: begin
            wr = 1'b0; lo_we = 1'b1;
          end
          FN_DSLLV: val = vt << vs[5:0];
          FN_DSRLV: val = vt >> vs[5:0];
          FN_DSRAV: val = $signed(vt) >>> vs[5:0];
          FN_MULT, FN_MULTU: is_mul = 1'b1;
          FN_DIV, FN_DIVU: begin
            wr = 1'b0; is_div = (vt[31:0] != 32'd0);
          end
          FN_ADD, FN_ADDU: val = sx32(vs[31:0] + vt[31:0]);
          FN_SUB, FN_SUBU: val = sx32(vs[31:0] - vt[31:0]);
          FN_AND: val = vs & vt;
          FN_OR:  val = vs | vt;
          FN_XOR: val = vs ^ vt;
          FN_NOR: val = ~(vs | vt);
          FN_SLT:  val = {63'd0, $signed(vs) < $signed(vt)};
          FN_SLTU: val = {63'd0, vs < vt};
          FN_DADD, FN_DADDU: val = vs + vt;
          FN_DSUB, FN_DSUBU: val = vs - vt;
          FN_DSLL: val = vt << sa;
          FN_DSRL: val = vt >> sa;
          FN_DSRA: val = $signed(vt) >>> sa;
          FN_DSLL32: begin
            sh6 = {1'b1, sa}; val = vt << sh6;
          end
          FN_DSRL32: begin
            sh6 = {1'b1, sa}; val = vt >> sh6;
          end
          FN_DSRA32: begin
            sh6 = {1'b1, sa}; val = $signed(vt) >>> sh6;
          end
          default: begin
            wr = 1'b0; uns = 1'b1;
          end
        endcase
      end
      OP_REGIMM: begin
        isbr = 1'b1;
        case (rt)
          5'd0, 5'd2, 5'd16, 5'd18: cond = vs[63];
          5'd1, 5'd3, 5'd17, 5'd19: cond = !vs[63];
          default: begin
            isbr = 1'b0; uns = 1'b1;
          end
        endcase
        if (isbr) begin
          likely = rt[1];
          if (rt[4]) begin
            wr = 1'b1; dst = 5'd31; val = link;
          end
        end
      end
      OP_J, OP_JAL: begin
        tk = 1'b1;
        tgt = {(pc_r[31:28] + {3'd0, &pc_r[27:2]}), ins_r[25:0], 2'b00};
        if (op == OP_JAL) begin
          wr = 1'b1; dst = 5'd31; val = link;
        end
      end
      OP_BEQ, OP_BEQL: begin
        isbr = 1'b1; cond = (vs == vt); likely = (op == OP_BEQL);
      end
      OP_BNE, OP_BNEL: begin
        isbr = 1'b1; cond = (vs != vt); likely = (op == OP_BNEL);
      end
      OP_BLEZ, OP_BLEZL: begin
        isbr = 1'b1; cond = !($signed(vs) > 64'sd0); likely = (op == OP_BLEZL);
      end
      OP_BGTZ, OP_BGTZL: begin
        isbr = 1'b1; cond = ($signed(vs) > 64'sd0); likely = (op == OP_BGTZL);
      end
      OP_ADDI, OP_ADDIU: begin
        wr = 1'b1; dst = rt; val = sx32(vs[31:0] + imm_s[31:0]);
      end
      OP_SLTI: begin
        wr = 1'b1; dst = rt; val = {63'd0, $signed(vs) < $signed(imm_s)};
      end
      OP_SLTIU: begin
        wr = 1'b1; dst = rt; val = {63'd0, vs < imm_s};
      end
      OP_ANDI: begin
        wr = 1'b1; dst = rt; val = vs & imm_u;
      end
      OP_ORI: begin
        wr = 1'b1; dst = rt; val = vs | imm_u;
      end
      OP_XORI: begin
        wr = 1'b1; dst = rt; val = vs ^ imm_u;
      end
      OP_LUI: begin
        wr = 1'b1; dst = rt; val = sx32({ins_r[15:0], 16'd0});
      end
      OP_DADDI, OP_DADDIU: begin
        wr = 1'b1; dst = rt; val = vs + imm_s;
      end
      default: uns = 1'b1;
    endcase
    if (isbr) begin
      if (cond) begin
        tk = 1'b1; tgt = btgt;
      end else if (likely) begin
        nul = 1'b1;
      end
    end
    if (uns) begin
      wr = 1'b0; tk = 1'b0; nul = 1'b0;
    end
    if (!tk) tgt = 32'd0;
    if (!(wr && dst != 5'd0)) begin
      wr = 1'b0; dst = 5'd0; val = 64'd0;
    end
  end

  // multiply operands and registered product
  logic [63:0] prod_r;
  logic [32:0] ma, mb;
  logic [65:0] mfull;
  assign ma = {fn == FN_MULT && vs[31], vs[31:0]};
  assign mb = {fn == FN_MULT && vt[31], vt[31:0]};
  assign mfull = $signed(ma) * $signed(mb);

  // divider: restoring, one quotient bit per cycle
  logic [31:0] dq_r, dd_r;
  logic [32:0] drem_r;
  logic [4:0]  dcnt_r;
  logic        dna_r, dnb_r;
  logic [32:0] dtry;
  logic [31:0] dq_f, dr_f;
  logic [31:0] da_abs, db_abs;
  logic        dsg;
  assign dsg = (fn == FN_DIV);
  assign da_abs = (dsg && vs[31]) ? 32'd0 - vs[31:0] : vs[31:0];
  assign db_abs = (dsg && vt[31]) ? 32'd0 - vt[31:0] : vt[31:0];
  assign dtry = {drem_r[31:0], dq_r[31]} - {1'b0, dd_r};
  logic [31:0] dq_nx;
  logic [32:0] drem_nx;
  always_comb begin
    if (!dtry[32]) begin
      drem_nx = dtry;
      dq_nx = {dq_r[30:0], 1'b1};
    end else begin
      drem_nx = {drem_r[31:0], dq_r[31]};
      dq_nx = {dq_r[30:0], 1'b0};
    end
    dq_f = (dna_r != dnb_r) ? 32'd0 - dq_nx : dq_nx;
    dr_f = dna_r ? 32'd0 - drem_nx[31:0] : drem_nx[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (is_mul) state_nxt = S_MUL;
        else if (is_div) state_nxt = S_DIV;
        else state_nxt = S_OUT;
      end
      S_MUL: state_nxt = S_OUT;
      S_DIV: if (dcnt_r == 5'd31) state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  logic        wb_en;
  logic [4:0]  wb_idx;
  logic [63:0] wb_val;
  always_comb begin
    wb_en = 1'b0; wb_idx = dst; wb_val = val;
    if (state_r == S_EXEC && !is_mul && wr) wb_en = 1'b1;
    if (state_r == S_MUL) begin
      wb_idx = rd; wb_val = sx32(prod_r[31:0]);
      wb_en = (rd != 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      ins_r <= in_data.instruction;
      pc_r  <= in_data.inst_address;
    end
    if (state_r == S_IDLE) begin
      rd_s_r <= gpr_mem[in_data.instruction[25:21]];
      rd_t_r <= gpr_mem[in_data.instruction[20:16]];
    end
    if (wb_en) gpr_mem[wb_idx] <= wb_val;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      prod_r <= mfull[63:0];
      res_r <= '{reg_write: wr, reg_index: dst, reg_value: val, branch_taken: tk,
                 branch_target: tgt, nullify_next: nul, unsupported: uns};
      dq_r <= da_abs;
      dd_r <= db_abs;
      drem_r <= 33'd0;
      dna_r <= dsg && vs[31];
      dnb_r <= dsg && vt[31];
    end
    if (state_r == S_MUL) begin
      res_r.reg_write <= wb_en;
      res_r.reg_index <= wb_en ? rd : 5'd0;
      res_r.reg_value <= wb_en ? sx32(prod_r[31:0]) : 64'd0;
    end
    if (state_r == S_DIV) begin
      dq_r <= dq_nx;
      drem_r <= drem_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gpr_vld_r <= 32'd0;
      hi_r      <= 64'd0;
      lo_r      <= 64'd0;
      dcnt_r    <= 5'd0;
    end else begin
      state_r <= state_nxt;
      if (wb_en) gpr_vld_r[wb_idx] <= 1'b1;
      if (state_r == S_EXEC) begin
        dcnt_r <= 5'd0;
        if (hi_we) hi_r <= hi_v;
        if (lo_we) lo_r <= lo_v;
      end
      if (state_r == S_MUL) begin
        lo_r <= sx32(prod_r[31:0]);
        hi_r <= sx32(prod_r[63:32]);
      end
      if (state_r == S_DIV) begin
        dcnt_r <= dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          lo_r <= sx32(dq_f);
          hi_r <= sx32(dr_f);
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// testbench for mips64_integer_execute: random and directed instruction words
// checked against an in-bench model of the register file, hi/lo and branches
// depends on mie_pkg and the block under test
module testbench;
  import mie_pkg::*;

  class exec_scoreboard;
    logic [63:0] gpr [32];
    logic [63:0] hi_q, lo_q;
    mie_out_t    pending [$];
    int          errors;
    int          checked;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      hi_q = '0;
      lo_q = '0;
      errors = 0;
      checked = 0;
    endfunction

    function automatic logic [63:0] sext(input logic [31:0] v);
      return {{32{v[31]}}, v};
    endfunction

    function automatic logic lts(input logic [63:0] a, input logic [63:0] b);
      return $signed(a) < $signed(b);
    endfunction

    function void note_word(input mie_in_t w);
      logic [31:0] ins, pc, pc4, btgt, tgt, q, r, a, b;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa, dst;
      logic [63:0] imm_s, imm_u, vs, vt, lnk, val, p;
      logic        wr, tk, nul, uns, cnd, lk, isbr, na, nb;
      mie_out_t    res;
      ins = w.instruction;
      pc = w.inst_address;
      pc4 = pc + 32'd4;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
      rd = ins[15:11]; sa = ins[10:6]; fn = ins[5:0];
      imm_s = {{48{ins[15]}}, ins[15:0]};
      imm_u = {48'd0, ins[15:0]};
      vs = (rs == 0) ? 64'd0 : gpr[rs];
      vt = (rt == 0) ? 64'd0 : gpr[rt];
      btgt = pc + 32'd4 + {imm_s[29:0], 2'b00};
      lnk = {32'd0, pc + 32'd8};
      wr = 0; tk = 0; nul = 0; uns = 0; cnd = 0; lk = 0; isbr = 0;
      dst = 0; val = 0; tgt = 0;
      case (op)
        OP_SPECIAL: begin
          wr = 1; dst = rd;
          case (fn)
            FN_SLL:    val = sext(vt[31:0] << sa);
            FN_SRL:    val = sext(vt[31:0] >> sa);
            FN_SRA:    val = sext($signed(vt[31:0]) >>> sa);
            FN_SLLV:   val = sext(vt[31:0] << vs[4:0]);
            FN_SRLV:   val = sext(vt[31:0] >> vs[4:0]);
            FN_SRAV:   val = sext($signed(vt[31:0]) >>> vs[4:0]);
            FN_JR:     begin wr = 0; tk = 1; tgt = vs[31:0]; end
            FN_JALR:   begin val = lnk; tk = 1; tgt = vs[31:0]; end
            FN_MOVZ:   begin wr = (vt == 0); val = vs; end
            FN_MOVN:   begin wr = (vt != 0); val = vs; end
            FN_MFHI:   val = hi_q;
            FN_MTHI:   begin wr = 0; hi_q = vs; end
            FN_MFLO:   val = lo_q;
            FN_MTLO:   begin wr = 0; lo_q = vs; end
            FN_DSLLV:  val = vt << vs[5:0];
            FN_DSRLV:  val = vt >> vs[5:0];
            FN_DSRAV:  val = $signed(vt) >>> vs[5:0];
            FN_MULT, FN_MULTU: begin
              if (fn == FN_MULT) p = sext(vs[31:0]) * sext(vt[31:0]);
              else p = {32'd0, vs[31:0]} * {32'd0, vt[31:0]};
              lo_q = sext(p[31:0]);
              hi_q = sext(p[63:32]);
              val = lo_q;
            end
            FN_DIV, FN_DIVU: begin
              wr = 0;
              a = vs[31:0]; b = vt[31:0]; na = 0; nb = 0;
              if (b != 0) begin
                if (fn == FN_DIV) begin
                  na = a[31]; nb = b[31];
                  if (na) a = -a;
                  if (nb) b = -b;
                end
                q = a / b;
                r = a % b;
                if (na != nb) q = -q;
                if (na) r = -r;
                lo_q = sext(q);
                hi_q = sext(r);
              end
            end
            FN_ADD, FN_ADDU: val = sext(vs[31:0] + vt[31:0]);
            FN_SUB, FN_SUBU: val = sext(vs[31:0] - vt[31:0]);
            FN_AND:    val = vs & vt;
            FN_OR:     val = vs | vt;
            FN_XOR:    val = vs ^ vt;
            FN_NOR:    val = ~(vs | vt);
            FN_SLT:    val = {63'd0, lts(vs, vt)};
            FN_SLTU:   val = {63'd0, vs < vt};
            FN_DADD, FN_DADDU: val = vs + vt;
            FN_DSUB, FN_DSUBU: val = vs - vt;
            FN_DSLL:   val = vt << sa;
            FN_DSRL:   val = vt >> sa;
            FN_DSRA:   val = $signed(vt) >>> sa;
            FN_DSLL32: val = vt << (sa + 32);
            FN_DSRL32: val = vt >> (sa + 32);
            FN_DSRA32: val = $signed(vt) >>> (sa + 32);
            default:   begin wr = 0; uns = 1; end
          endcase
        end
        OP_REGIMM: begin
          isbr = 1;
          case (rt)
            5'd0, 5'd2, 5'd16, 5'd18: cnd = vs[63];
            5'd1, 5'd3, 5'd17, 5'd19: cnd = !vs[63];
            default: begin isbr = 0; uns = 1; end
          endcase
          if (isbr) begin
            lk = rt[1];
            if (rt[4]) begin wr = 1; dst = 31; val = lnk; end
          end
        end
        OP_J, OP_JAL: begin
          tk = 1;
          tgt = {pc4[31:28], ins[25:0], 2'b00};
          if (op == OP_JAL) begin wr = 1; dst = 31; val = lnk; end
        end
        OP_BEQ, OP_BEQL:   begin isbr = 1; cnd = (vs == vt); lk = (op == OP_BEQL); end
        OP_BNE, OP_BNEL:   begin isbr = 1; cnd = (vs != vt); lk = (op == OP_BNEL); end
        OP_BLEZ, OP_BLEZL: begin isbr = 1; cnd = !lts(0, vs); lk = (op == OP_BLEZL); end
        OP_BGTZ, OP_BGTZL: begin isbr = 1; cnd = lts(0, vs); lk = (op == OP_BGTZL); end
        OP_ADDI, OP_ADDIU: begin wr = 1; dst = rt; val = sext(vs[31:0] + imm_s[31:0]); end
        OP_SLTI:  begin wr = 1; dst = rt; val = {63'd0, lts(vs, imm_s)}; end
        OP_SLTIU: begin wr = 1; dst = rt; val = {63'd0, vs < imm_s}; end
        OP_ANDI:  begin wr = 1; dst = rt; val = vs & imm_u; end
        OP_ORI:   begin wr = 1; dst = rt; val = vs | imm_u; end
        OP_XORI:  begin wr = 1; dst = rt; val = vs ^ imm_u; end
        OP_LUI:   begin wr = 1; dst = rt; val = sext({ins[15:0], 16'd0}); end
        OP_DADDI, OP_DADDIU: begin wr = 1; dst = rt; val = vs + imm_s; end
        default:  uns = 1;
      endcase
      if (isbr) begin
        if (cnd) begin tk = 1; tgt = btgt; end
        else if (lk) nul = 1;
      end
      if (uns) begin wr = 0; tk = 0; nul = 0; end
      if (!tk) tgt = 0;
      if (wr && dst != 0) gpr[dst] = val;
      else begin wr = 0; dst = 0; val = 0; end
      res.reg_write = wr;
      res.reg_index = dst;
      res.reg_value = val;
      res.branch_taken = tk;
      res.branch_target = tgt;
      res.nullify_next = nul;
      res.unsupported = uns;
      pending.push_back(res);
    endfunction

    function void check_result(input mie_out_t got);
      mie_out_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.reg_write !== e.reg_write) begin
        $error("reg_write exp %0d got %0d", e.reg_write, got.reg_write); errors++;
      end
      if (got.reg_index !== e.reg_index) begin
        $error("reg_index exp %0d got %0d", e.reg_index, got.reg_index); errors++;
      end
      if (got.reg_value !== e.reg_value) begin
        $error("reg_value exp %h got %h", e.reg_value, got.reg_value); errors++;
      end
      if (got.branch_taken !== e.branch_taken) begin
        $error("branch_taken exp %0d got %0d", e.branch_taken, got.branch_taken); errors++;
      end
      if (got.branch_target !== e.branch_target) begin
        $error("branch_target exp %h got %h", e.branch_target, got.branch_target); errors++;
      end
      if (got.nullify_next !== e.nullify_next) begin
        $error("nullify_next exp %0d got %0d", e.nullify_next, got.nullify_next); errors++;
      end
      if (got.unsupported !== e.unsupported) begin
        $error("unsupported exp %0d got %0d", e.unsupported, got.unsupported); errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 600000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mie_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  mie_out_t out_data;

  exec_scoreboard sb;
  int  cycles;
  int  sent;
  bit  quiet;
  bit  hold_out;

  mips64_integer_execute u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) out_stall <= 1;
      else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end else out_stall <= 0;
    end
  end

  // leaves in_valid high; the caller drops it once no word follows
  task automatic send_word(input logic [31:0] ins, input logic [31:0] pc);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 19);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_data.instruction <= ins;
    in_data.inst_address <= pc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word('{instruction: ins, inst_address: pc});
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sa,
                                        input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  localparam logic [5:0] FN_LIST [52] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_MOVZ,
    FN_MOVN, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_DSLLV, FN_DSRLV, FN_DSRAV,
    FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
    FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_DADD, FN_DADDU, FN_DSUB, FN_DSUBU,
    FN_DSLL, FN_DSRL, FN_DSRA, FN_DSLL32, FN_DSRL32, FN_DSRA32, FN_MULT, FN_DIV,
    FN_ADDU, FN_OR, FN_DSLLV, FN_SLT, FN_MOVZ, FN_MFLO, FN_MFHI, FN_DIVU, FN_MULTU};
  localparam logic [5:0] OP_LIST [24] = '{
    OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
    OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_BEQL, OP_BNEL,
    OP_BLEZL, OP_BGTZL, OP_DADDI, OP_DADDIU, OP_ORI, OP_LUI, OP_DADDIU};

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int k;
    w = $urandom();
    k = $urandom_range(0, 99);
    if (k < 8) return w;
    if (k < 50) begin
      w[31:26] = OP_SPECIAL;
      w[5:0] = FN_LIST[$urandom_range(0, 51)];
    end else w[31:26] = OP_LIST[$urandom_range(0, 23)];
    // bias operands toward a few registers so values chain
    if ($urandom_range(0, 3) != 0) begin
      w[25:21] = 5'($urandom_range(0, 7));
      w[20:16] = 5'($urandom_range(0, 7));
      w[15:11] = 5'($urandom_range(0, 7));
    end
    if (w[31:26] == OP_REGIMM && $urandom_range(0, 3) != 0)
      w[20:16] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 2'b00, 2'($urandom_range(0, 3))};
    return w;
  endfunction

  initial begin
    logic [31:0] pc;
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    sent = 0;
    quiet = 0;
    hold_out = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, register zero, zero divisor, overflow, links, likely
    send_word(itype(OP_LUI, 5'd0, 5'd1, 16'h8000), 32'h0);
    send_word(itype(OP_ORI, 5'd1, 5'd1, 16'hffff), 32'hffff_fffc);
    send_word(itype(OP_ADDIU, 5'd0, 5'd2, 16'hffff), 32'h0000_1000);
    send_word(itype(OP_LUI, 5'd0, 5'd0, 16'h1234), 32'h0);
    send_word(rtype(5'd1, 5'd2, 5'd3, 5'd0, FN_DIV), 32'h0);
    send_word(rtype(5'd0, 5'd0, 5'd3, 5'd0, FN_MFLO), 32'h0);
    send_word(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU), 32'h0);
    send_word(rtype(5'd0, 5'd0, 5'd4, 5'd0, FN_MFHI), 32'h0);
    send_word(rtype(5'd2, 5'd2, 5'd5, 5'd0, FN_MULT), 32'h0);
    send_word(rtype(5'd2, 5'd2, 5'd6, 5'd0, FN_MULTU), 32'h0);
    send_word(rtype(5'd0, 5'd2, 5'd7, 5'd31, FN_DSRA32), 32'h0);
    send_word(rtype(5'd2, 5'd0, 5'd8, 5'd0, FN_MOVZ), 32'h0);
    send_word(rtype(5'd2, 5'd0, 5'd8, 5'd0, FN_MOVN), 32'h0);
    send_word(rtype(5'd2, 5'd0, 5'd9, 5'd0, FN_JALR), 32'hffff_fffc);
    send_word(itype(OP_REGIMM, 5'd2, 5'd17, 16'h8000), 32'h0000_0010);
    send_word(itype(OP_REGIMM, 5'd2, 5'd18, 16'h7fff), 32'hffff_fff8);
    send_word(itype(OP_BEQL, 5'd1, 5'd2, 16'h0001), 32'h0);
    send_word({OP_JAL, 26'h3ff_ffff}, 32'h0fff_fffc);
    send_word({OP_J, 26'h0}, 32'hffff_fffc);
    send_word(itype(OP_REGIMM, 5'd0, 5'd5, 16'h0), 32'h0);
    send_word(32'hffff_ffff, 32'h0);
    send_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'd1), 32'h0);
    send_word(itype(OP_DADDI, 5'd2, 5'd10, 16'h8000), 32'h0);
    send_word(itype(OP_SLTIU, 5'd2, 5'd11, 16'hffff), 32'h0);
    in_valid <= 0;

    // sender pauses until everything has drained
    while (sb.pending.size() != 0) @(negedge clk);

    // receiver holds off while words keep coming
    fork
      begin
        hold_out = 1;
        repeat (200) @(negedge clk);
        hold_out = 0;
      end
      repeat (10) send_word(rand_word(), $urandom());
    join

    pc = 32'h0040_0000;
    for (int i = 0; i < 1720; i++) begin
      if (i == 1500) quiet = 1;
      send_word(rand_word(), ($urandom_range(0, 9) == 0) ? $urandom() : pc);
      pc += 4;
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d instruction words, checked %0d results", sent, sb.checked);
    $display("covered alu, shifts, hi/lo, mul/div, branches and jumps under stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
